[hw/rtl/glr_pkg.sv]
// Shared constants for the gcd/lcm list reducer.
// No dependencies; used by every module in hw/rtl.
`default_nettype none
package glr_pkg;

	// Width of the running accumulator and of every arithmetic unit
	localparam int ACC_BITS = 63;

	// Default width of the two's complement operand as seen by the block
	localparam int DEFAULT_VALUE_BITS = 64;

	// Largest value that fits the accumulator
	localparam logic [ACC_BITS-1:0] ACC_MAX = {ACC_BITS{1'b1}};

	// List operation codes
	localparam logic OP_GCD = 1'b0;
	localparam logic OP_LCM = 1'b1;

endpackage
`default_nettype wire

[hw/rtl/glr_gcd.sv]
// Binary (shift and subtract) gcd unit, one step per cycle.
// Depends on glr_pkg for the default width.
`default_nettype none
module glr_gcd #(
	parameter int WIDTH = glr_pkg::ACC_BITS
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [WIDTH-1:0] a_in,
	input  wire logic [WIDTH-1:0] b_in,
	output logic                  done,
	output logic [WIDTH-1:0]      gcd_out
);

	localparam int KW = $clog2(WIDTH);

	logic             busy_q;
	logic             done_q;
	logic [WIDTH-1:0] a_q;
	logic [WIDTH-1:0] b_q;
	logic [KW-1:0]    k_q;
	logic [WIDTH-1:0] g_q;
	logic             finish;

	// One operand has reached zero: the other, rescaled, is the gcd
	assign finish = busy_q && ((a_q == '0) || (b_q == '0));

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (finish) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Datapath: strip shared twos, strip single twos, subtract smaller from larger
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a_in;
			b_q <= b_in;
			k_q <= '0;
		end else if (busy_q) begin
			if (a_q == '0) begin
				g_q <= b_q << k_q;
			end else if (b_q == '0) begin
				g_q <= a_q << k_q;
			end else if (!a_q[0] && !b_q[0]) begin
				a_q <= a_q >> 1;
				b_q <= b_q >> 1;
				k_q <= k_q + 1'b1;
			end else if (!a_q[0]) begin
				a_q <= a_q >> 1;
			end else if (!b_q[0]) begin
				b_q <= b_q >> 1;
			end else if (a_q >= b_q) begin
				a_q <= a_q - b_q;
			end else begin
				b_q <= b_q - a_q;
			end
		end
	end

	assign done    = done_q;
	assign gcd_out = g_q;

endmodule
`default_nettype wire

[hw/rtl/glr_divider.sv]
// Restoring divider, one quotient bit per cycle.
// Depends on glr_pkg for the default width. Divisor must be nonzero.
`default_nettype none
module glr_divider #(
	parameter int WIDTH = glr_pkg::ACC_BITS
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [WIDTH-1:0] num,
	input  wire logic [WIDTH-1:0] den,
	output logic                  done,
	output logic [WIDTH-1:0]      quot
);

	localparam int CW = $clog2(WIDTH);

	logic             busy_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	logic [WIDTH-1:0] n_q;
	logic [WIDTH-1:0] d_q;
	logic [WIDTH-1:0] r_q;
	logic [WIDTH:0]   trial;
	logic [WIDTH:0]   diff;
	logic             ge;

	// Shift in the next dividend bit and try the subtract
	assign trial = {r_q, n_q[WIDTH-1]};
	assign diff  = trial - {1'b0, d_q};
	assign ge    = trial >= {1'b0, d_q};

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(WIDTH - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: quotient bits shift into the dividend register
	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			d_q <= den;
			r_q <= '0;
		end else if (busy_q) begin
			r_q <= ge ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
			n_q <= {n_q[WIDTH-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = n_q;

endmodule
`default_nettype wire

[hw/rtl/glr_multiplier.sv]
// Shift-and-add multiplier, MSB first, one multiplier bit per cycle.
// Flags any product that does not fit WIDTH bits. Depends on glr_pkg.
`default_nettype none
module glr_multiplier #(
	parameter int WIDTH = glr_pkg::ACC_BITS
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [WIDTH-1:0] mul_a,
	input  wire logic [WIDTH-1:0] mul_b,
	output logic                  done,
	output logic [WIDTH-1:0]      prod,
	output logic                  ovf
);

	localparam int CW = $clog2(WIDTH);

	logic             busy_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	logic [WIDTH-1:0] a_q;
	logic [WIDTH-1:0] b_q;
	logic [WIDTH-1:0] p_q;
	logic             ovf_q;
	logic [WIDTH+1:0] step_sum;

	// Partial product doubled plus the multiplicand when the current bit is set
	assign step_sum = {1'b0, p_q, 1'b0} + (WIDTH+2)'(a_q[WIDTH-1] ? b_q : '0);

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(WIDTH - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: once the partial product leaves WIDTH bits the flag sticks
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= mul_a;
			b_q   <= mul_b;
			p_q   <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			a_q <= a_q << 1;
			p_q <= step_sum[WIDTH-1:0];
			if (step_sum[WIDTH+1:WIDTH] != 2'b00) begin
				ovf_q <= 1'b1;
			end
		end
	end

	assign done = done_q;
	assign prod = p_q;
	assign ovf  = ovf_q;

endmodule
`default_nettype wire

[hw/rtl/gcd_lcm_list_reducer.sv]
// Folds a stream of signed values into their gcd or lcm, one result per list.
// From accept to ready: a list start passes ST_FIN; a gcd step adds ST_GCD (binary gcd,
// one shift or subtract a cycle); an lcm step adds a division (ST_DIV) and a multiply (ST_MUL).
// One transaction is in work at a time; a list end also waits for a free output register.
// Reset (arst_n, asynchronous, active low) clears the accumulator, mode and overflow flag.
// Depends on glr_pkg, glr_gcd, glr_divider, glr_multiplier.
`default_nettype none
module gcd_lcm_list_reducer #(
	parameter int VALUE_BITS = glr_pkg::DEFAULT_VALUE_BITS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [63:0] s_axis_tdata,  // operand[63:0]
	input  wire logic [1:0]  s_axis_tuser,  // operation[0], first_item[1]
	input  wire logic        s_axis_tlast,  // last_item
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [63:0]      m_axis_tdata,  // result[62:0], zero pad[63]
	output logic             m_axis_tuser   // overflow
);

	localparam int W = glr_pkg::ACC_BITS;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_GCD  = 5'b00010,
		ST_DIV  = 5'b00100,
		ST_MUL  = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

	state_t state_q;

	logic [W-1:0] acc_q;
	logic         mode_q;
	logic         ovf_seen_q;
	logic [W-1:0] v_q;
	logic         last_q;
	logic         out_valid_q;
	logic [W-1:0] out_result_q;
	logic         out_ovf_q;

	logic [VALUE_BITS-1:0] raw;
	logic [VALUE_BITS-1:0] mag;
	logic [63:0]           mag_ext;
	logic [W-1:0]          v_in;
	logic                  in_xact;
	logic                  in_first;
	logic                  in_op;

	logic         gcd_start;
	logic         gcd_done;
	logic [W-1:0] gcd_val;
	logic         div_start;
	logic         div_done;
	logic [W-1:0] div_quot;
	logic         mul_done;
	logic [W-1:0] mul_prod;
	logic         mul_ovf;
	logic         fin_load;

	// Operand magnitude, clamped to the accumulator range
	assign raw     = s_axis_tdata[VALUE_BITS-1:0];
	assign mag     = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
	assign mag_ext = 64'(mag);
	assign v_in    = mag_ext[63] ? glr_pkg::ACC_MAX : mag_ext[W-1:0];

	assign in_op    = s_axis_tuser[0];
	assign in_first = s_axis_tuser[1];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_xact       = s_axis_tvalid && s_axis_tready;

	// Unit starts
	assign gcd_start = in_xact && !in_first;
	assign div_start = (state_q == ST_GCD) && gcd_done && (mode_q == glr_pkg::OP_LCM)
		&& (gcd_val != '0);
	assign fin_load  = (state_q == ST_FIN) && last_q && (!out_valid_q || m_axis_tready);

	glr_gcd #(
		.WIDTH(W)
	) u_gcd (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (gcd_start),
		.a_in    (acc_q),
		.b_in    (v_in),
		.done    (gcd_done),
		.gcd_out (gcd_val)
	);

	glr_divider #(
		.WIDTH(W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (acc_q),
		.den    (gcd_val),
		.done   (div_done),
		.quot   (div_quot)
	);

	glr_multiplier #(
		.WIDTH(W)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_done),
		.mul_a  (div_quot),
		.mul_b  (v_q),
		.done   (mul_done),
		.prod   (mul_prod),
		.ovf    (mul_ovf)
	);

	// Sequencer and list state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			acc_q      <= '0;
			mode_q     <= glr_pkg::OP_GCD;
			ovf_seen_q <= 1'b0;
			last_q     <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xact) begin
						last_q <= s_axis_tlast;
						if (in_first) begin
							acc_q      <= v_in;
							mode_q     <= in_op;
							ovf_seen_q <= 1'b0;
							state_q    <= ST_FIN;
						end else begin
							state_q <= ST_GCD;
						end
					end
				end
				ST_GCD: begin
					if (gcd_done) begin
						if (mode_q == glr_pkg::OP_GCD) begin
							acc_q   <= gcd_val;
							state_q <= ST_FIN;
						end else if (gcd_val == '0) begin
							acc_q   <= '0;
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (mul_done) begin
						if (mul_ovf) begin
							acc_q      <= glr_pkg::ACC_MAX;
							ovf_seen_q <= 1'b1;
						end else begin
							acc_q <= mul_prod;
						end
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!last_q) begin
						state_q <= ST_IDLE;
					end else if (fin_load) begin
						acc_q      <= '0;
						mode_q     <= glr_pkg::OP_GCD;
						ovf_seen_q <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Magnitude kept for the multiply
	always_ff @(posedge clk) begin
		if (in_xact) begin
			v_q <= v_in;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			out_result_q <= acc_q;
			out_ovf_q    <= ovf_seen_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_result_q};
	assign m_axis_tuser  = out_ovf_q;

endmodule
`default_nettype wire
